// ===== design/csrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// csrcc_pkg
// Types, codes and CRC-16 helpers for the config stream receiver.
// ----------------------------------------------------------------------------
package csrcc_pkg;

    localparam logic [7:0]  CMD_RESET        = 8'd33;
    localparam logic [3:0]  LEN_HEADER_SHORT = 4'd6;
    localparam logic [3:0]  LEN_HEADER_LONG  = 4'd7;
    localparam logic [3:0]  LEN_DATA         = 4'd8;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_STEP       = 32'd8;
    localparam int          QUEUE_DEPTH      = 2;
    localparam int          QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CLS_FOREIGN,
        CLS_HDR_SHORT,
        CLS_HDR_LONG,
        CLS_DATA,
        CLS_BAD_LEN
    } frame_class_t;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_HEADER    = 3'd1,
        ST_DATA      = 3'd2,
        ST_DONE_OK   = 3'd3,
        ST_DONE_BAD  = 3'd4,
        ST_BUSY      = 3'd5,
        ST_NO_HEADER = 3'd6,
        ST_BAD_LEN   = 3'd7
    } status_t;

    // Classified item. word holds bytes 0-3 big-endian, field bytes 4-5,
    // data_crc the CRC of the eight bytes from a zero start.
    typedef struct packed {
        frame_class_t cls;
        logic [31:0]  word;
        logic [15:0]  field;
        logic [15:0]  data_crc;
    } entry_t;

    function automatic logic [15:0] crc_fold_byte(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Eight bytes, byte 0 in the top bits.
    function automatic logic [15:0] crc_fold_word(logic [15:0] c, logic [63:0] w);
        logic [15:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = crc_fold_byte(r, w[63 - 8*i -: 8]);
        end
        return r;
    endfunction

endpackage

// ===== design/config_stream_receiver_crc_check.sv =====
// ----------------------------------------------------------------------------
// config_stream_receiver_crc_check
// Config data stream receiver: header/data frame decode, CRC-16 check.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    command_byte, frame_length, data_b0..b7
// m_        out  m_valid/m_ready    status, computed_crc, uncompressed_size,
//                                   bytes_received
// cfg_      in   cfg_valid/cfg_ready cfg_data (stream command)
//
// One item per cycle sustained while m_ready is high. Path to m_valid (front
// register, queue entry, then back state update into the output
// register). The 64-bit CRC fold is split between front (data part) and
// back (state part). Reset is synchronous, active low, and needs no clearing
// pass. Front and back stall independently through a two-item queue.
// ----------------------------------------------------------------------------
module config_stream_receiver_crc_check
    import csrcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_command_byte,
    input  logic [3:0]  s_frame_length,
    input  logic [7:0]  s_data_b0,
    input  logic [7:0]  s_data_b1,
    input  logic [7:0]  s_data_b2,
    input  logic [7:0]  s_data_b3,
    input  logic [7:0]  s_data_b4,
    input  logic [7:0]  s_data_b5,
    input  logic [7:0]  s_data_b6,
    input  logic [7:0]  s_data_b7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_computed_crc,
    output logic [31:0] m_uncompressed_size,
    output logic [31:0] m_bytes_received
);

    logic [7:0] stream_command_reg;
    logic [7:0] stream_command_next;
    logic       f_valid;
    logic       f_ready;
    entry_t     f_data;
    logic       b_valid;
    logic       b_ready;
    entry_t     b_data;

    assign cfg_ready           = 1'b1;
    assign stream_command_next = (cfg_valid && cfg_ready) ? cfg_data : stream_command_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_command_reg <= CMD_RESET;
        end else begin
            stream_command_reg <= stream_command_next;
        end
    end

    csrcc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .stream_command (stream_command_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command_byte (s_command_byte),
        .s_frame_length (s_frame_length),
        .s_data_b0      (s_data_b0),
        .s_data_b1      (s_data_b1),
        .s_data_b2      (s_data_b2),
        .s_data_b3      (s_data_b3),
        .s_data_b4      (s_data_b4),
        .s_data_b5      (s_data_b5),
        .s_data_b6      (s_data_b6),
        .s_data_b7      (s_data_b7),
        .q_valid        (f_valid),
        .q_ready        (f_ready),
        .q_data         (f_data)
    );

    csrcc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    csrcc_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (b_valid),
        .q_ready             (b_ready),
        .q_data              (b_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_computed_crc      (m_computed_crc),
        .m_uncompressed_size (m_uncompressed_size),
        .m_bytes_received    (m_bytes_received)
    );

    a_header_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_HEADER |->
            m_bytes_received == '0 && m_computed_crc == CRC_INIT)
        else $error("header result without cleared count and CRC");

    a_data_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DATA |-> m_bytes_received >= COUNT_STEP)
        else $error("data result with fewer than eight bytes counted");

    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !f_ready |=> f_valid && $stable(f_data))
        else $error("front item lost while queue full");

endmodule

// ===== design/csrcc_front.sv =====
// ----------------------------------------------------------------------------
// csrcc_front
// Takes frames, classifies them by command and length, pre-computes the
// data part of the CRC and holds the result in one register stage.
// ----------------------------------------------------------------------------
module csrcc_front
    import csrcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  stream_command,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_command_byte,
    input  logic [3:0]  s_frame_length,
    input  logic [7:0]  s_data_b0,
    input  logic [7:0]  s_data_b1,
    input  logic [7:0]  s_data_b2,
    input  logic [7:0]  s_data_b3,
    input  logic [7:0]  s_data_b4,
    input  logic [7:0]  s_data_b5,
    input  logic [7:0]  s_data_b6,
    input  logic [7:0]  s_data_b7,
    output logic        q_valid,
    input  logic        q_ready,
    output entry_t      q_data
);

    logic         valid_reg;
    logic         valid_next;
    entry_t       entry_reg;
    entry_t       entry_next;
    frame_class_t cls;
    logic [63:0]  bytes;

    assign bytes = {s_data_b0, s_data_b1, s_data_b2, s_data_b3,
                    s_data_b4, s_data_b5, s_data_b6, s_data_b7};

    always_comb begin
        if (s_command_byte != stream_command) begin
            cls = CLS_FOREIGN;
        end else begin
            case (s_frame_length)
                LEN_HEADER_SHORT: cls = CLS_HDR_SHORT;
                LEN_HEADER_LONG:  cls = CLS_HDR_LONG;
                LEN_DATA:         cls = CLS_DATA;
                default:          cls = CLS_BAD_LEN;
            endcase
        end
    end

    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                entry_next.cls      = cls;
                entry_next.word     = bytes[63:32];
                entry_next.field    = bytes[31:16];
                entry_next.data_crc = crc_fold_word(16'h0000, bytes);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign q_valid = valid_reg;
    assign q_data  = entry_reg;

endmodule

// ===== design/csrcc_queue.sv =====
// ----------------------------------------------------------------------------
// csrcc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module csrcc_queue
    import csrcc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign wr_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] r;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/csrcc_back.sv =====
// ----------------------------------------------------------------------------
// csrcc_back
// Transfer state, running CRC and byte count; one result per item into the
// output register.
// ----------------------------------------------------------------------------
module csrcc_back
    import csrcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  entry_t      q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_computed_crc,
    output logic [31:0] m_uncompressed_size,
    output logic [31:0] m_bytes_received
);

    logic        receiving_reg,  receiving_next;
    logic        awaiting_reg,   awaiting_next;
    logic [15:0] expected_reg,   expected_next;
    logic [31:0] csize_reg,      csize_next;
    logic [31:0] count_reg,      count_next;
    logic [15:0] crc_reg,        crc_next;
    logic [31:0] usize_reg,      usize_next;
    logic        out_valid_reg,  out_valid_next;
    status_t     out_status_reg, status;
    logic        take;

    assign q_ready = !out_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    always_comb begin
        receiving_next = receiving_reg;
        awaiting_next  = awaiting_reg;
        expected_next  = expected_reg;
        csize_next     = csize_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        usize_next     = usize_reg;
        status         = ST_IGNORED;
        case (q_data.cls)
            CLS_FOREIGN: status = ST_IGNORED;
            CLS_HDR_SHORT, CLS_HDR_LONG: begin
                if (q_data.cls == CLS_HDR_SHORT && receiving_reg) begin
                    status = ST_BUSY;
                end else begin
                    status         = ST_HEADER;
                    receiving_next = 1'b1;
                    awaiting_next  = 1'b1;
                    expected_next  = q_data.field;
                    csize_next     = q_data.word;
                    count_next     = '0;
                    crc_next       = CRC_INIT;
                end
            end
            CLS_DATA: begin
                if (!receiving_reg) begin
                    status = ST_NO_HEADER;
                end else begin
                    if (awaiting_reg) begin
                        awaiting_next = 1'b0;
                        usize_next    = q_data.word;
                    end
                    // CRC is linear: state shifted through 64 zero bits plus data part
                    crc_next = crc_fold_word(crc_reg, 64'd0) ^ q_data.data_crc;
                    if (count_reg > COUNT_MAX - COUNT_STEP) begin
                        count_next = COUNT_MAX;
                    end else begin
                        count_next = count_reg + COUNT_STEP;
                    end
                    if (count_next >= csize_reg) begin
                        receiving_next = 1'b0;
                        status = (crc_next == expected_reg) ? ST_DONE_OK : ST_DONE_BAD;
                    end else begin
                        status = ST_DATA;
                    end
                end
            end
            CLS_BAD_LEN: status = ST_BAD_LEN;
            default:     status = ST_IGNORED;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_ready) begin
            out_valid_next = q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            expected_reg  <= '0;
            csize_reg     <= '0;
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            usize_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                receiving_reg <= receiving_next;
                awaiting_reg  <= awaiting_next;
                expected_reg  <= expected_next;
                csize_reg     <= csize_next;
                count_reg     <= count_next;
                crc_reg       <= crc_next;
                usize_reg     <= usize_next;
            end
        end
        if (take) begin
            out_status_reg <= status;
        end
    end

    // State registers double as result payload: they only move on take.
    assign m_valid             = out_valid_reg;
    assign m_status            = out_status_reg;
    assign m_computed_crc      = crc_reg;
    assign m_uncompressed_size = usize_reg;
    assign m_bytes_received    = count_reg;

endmodule
